// ----- design/uer_pkg.sv -----
// shared types, widths and constants of the ultrasonic echo ranger
// no dependencies; imported by the core and by its checker

package uer_pkg;

   // widths of the tick counter, registers and result fields
   localparam int COUNTER_BITS = 8;
   localparam int FACTOR_W     = 12;
   localparam int TICKS_W      = 8;
   localparam int RANGE_W      = 10;
   localparam int SEG_W        = 7;
   localparam int DIGIT_W      = 4;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 12;

   // product of pulse width and factor, and the span handled by the divider
   localparam int PROD_W  = COUNTER_BITS + FACTOR_W;
   localparam int DIV_W   = 20;
   localparam int EXT_W   = (PROD_W > DIV_W) ? PROD_W : DIV_W;
   localparam int RECIP_W = 11;
   localparam int QUO_W   = 11;
   localparam int REM_W   = DIV_W + 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_FACTOR  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_TRIGGER = 1'b1;

   // register reset values
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 12'd1098;
   localparam logic [TICKS_W-1:0]  TICKS_RESET  = 8'd1;

   // divide by 1000: estimate with a reciprocal, then one correction step
   localparam logic [RANGE_W-1:0] RANGE_MAX = '1;
   localparam logic [EXT_W-1:0]   SAT_LIMIT = EXT_W'((2 ** RANGE_W) * 1000);
   localparam logic [RECIP_W-1:0] RECIP_1000 = 11'd1048;
   localparam logic [REM_W-1:0]   DIVISOR    = REM_W'(1000);

   // decimal digit extraction of a range value
   localparam int DIV10_MUL_W   = 8;
   localparam int DIV10_SHIFT   = 11;
   localparam int DIV100_MUL_W  = 6;
   localparam int DIV100_SHIFT  = 12;
   localparam int Q10_W         = 7;
   localparam logic [DIV10_MUL_W-1:0]  DIV10_MUL  = 8'd205;
   localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 6'd41;
   localparam logic [RANGE_W-1:0]      THOUSAND   = 10'd1000;
   localparam logic [DIGIT_W-1:0]      DIGIT_TEN  = 4'd10;

   // measurement phase
   typedef enum logic [2:0] {
      PH_TRIGGER   = 3'b001,
      PH_WAIT_RISE = 3'b010,
      PH_WAIT_FALL = 3'b100
   } phase_type;

   // per-item flags carried down the pipeline
   typedef struct packed {
      logic trig;
      logic fire;
      logic drop;
   } flags_type;

   // seven-segment pattern of one decimal digit, bit0 segment a
   function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
      logic [SEG_W-1:0] pat;
      unique case (digit)
         4'd0:    pat = 7'h3F;
         4'd1:    pat = 7'h06;
         4'd2:    pat = 7'h5B;
         4'd3:    pat = 7'h4F;
         4'd4:    pat = 7'h66;
         4'd5:    pat = 7'h6D;
         4'd6:    pat = 7'h7D;
         4'd7:    pat = 7'h07;
         4'd8:    pat = 7'h7F;
         4'd9:    pat = 7'h67;
         default: pat = '0;
      endcase
      return pat;
   endfunction

endpackage

// ----- design/ultrasonic_echo_ranger_core.sv -----
// ultrasonic echo ranger: trigger sequencing, echo edge capture, range and digits
// depends on uer_pkg
//
// pipeline: a result passes stage 1, stage 2, stage 3 and the output register after its tick is accepted
// throughput: one tick per cycle; rsp_stall backs up through the four stages
// reset: phase back to trigger, counters and last range cleared,
//    range factor back to 1098 and trigger length back to 1

module ultrasonic_echo_ranger_core
   import uer_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // tick input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_echo_level,
   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_trigger_level,
   output logic                  rsp_result_valid,
   output logic                  rsp_dropped,
   output logic [RANGE_W-1:0]    rsp_range_cm,
   output logic [SEG_W-1:0]      rsp_seg_ones,
   output logic [SEG_W-1:0]      rsp_seg_tens,
   output logic [SEG_W-1:0]      rsp_seg_hundreds,
   output logic [SEG_W-1:0]      rsp_seg_thousands,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // configuration registers
   logic [FACTOR_W-1:0]     factor_ff;
   logic [TICKS_W-1:0]      ticks_ff;

   // measurement state
   phase_type               phase_ff, phase_in;
   logic [COUNTER_BITS-1:0] tick_ff, tick_in, tick_now;
   logic [TICKS_W-1:0]      left_ff, left_in, left_ld, left_dec;
   logic [COUNTER_BITS-1:0] rise_ff, rise_in;
   logic [RANGE_W-1:0]      last_range_ff;
   logic [COUNTER_BITS-1:0] width;
   flags_type               flags_in;

   // pipeline stages
   logic                    s1_v_ff, s2_v_ff, s3_v_ff, rsp_v_ff;
   flags_type               s1_flags_ff, s2_flags_ff, s3_flags_ff;
   logic [PROD_W-1:0]       s1_prod_ff, s1_prod_in;
   logic                    s2_sat_ff, s2_sat_in;
   logic [DIV_W-1:0]        s2_p_ff, s2_p_in;
   logic [QUO_W-1:0]        s2_q0_ff, s2_q0_in;
   logic [RANGE_W-1:0]      s3_range_ff, s3_range_in;

   // output registers
   logic                    rsp_trig_ff, rsp_fire_ff, rsp_drop_ff;
   logic [RANGE_W-1:0]      rsp_range_ff;
   logic [SEG_W-1:0]        rsp_ones_ff, rsp_ones_in;
   logic [SEG_W-1:0]        rsp_tens_ff, rsp_tens_in;
   logic [SEG_W-1:0]        rsp_hund_ff, rsp_hund_in;
   logic [SEG_W-1:0]        rsp_thou_ff, rsp_thou_in;

   // handshake
   logic                    rsp_ready, s3_ready, s2_ready, s1_ready, accept;

   // divider and digit working values
   logic [EXT_W-1:0]        prod_ext;
   logic [DIV_W+RECIP_W-1:0] recip_prod;
   logic [REM_W-1:0]        q0_times;
   logic [REM_W-1:0]        rem;
   logic [QUO_W-1:0]        quo;
   logic [RANGE_W-1:0]      cm;
   logic [RANGE_W+DIV10_MUL_W-1:0]  prod10;
   logic [RANGE_W+DIV100_MUL_W-1:0] prod100;
   logic [Q10_W-1:0]        q10;
   logic [DIGIT_W-1:0]      q100;
   logic [RANGE_W-1:0]      ones_full;
   logic [Q10_W-1:0]        tens_full;
   logic [DIGIT_W-1:0]      hund_digit, thou_digit;

   // ready chain, collapsing bubbles
   assign rsp_ready = !rsp_v_ff || !rsp_stall;
   assign s3_ready  = !s3_v_ff || rsp_ready;
   assign s2_ready  = !s2_v_ff || s3_ready;
   assign s1_ready  = !s1_v_ff || s2_ready;
   assign req_stall = !s1_ready;
   assign accept    = req_valid && s1_ready;
   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FACTOR_RESET;
         ticks_ff  <= TICKS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_IDX_FACTOR:  factor_ff <= csr_data[FACTOR_W-1:0];
            CSR_IDX_TRIGGER: ticks_ff  <= csr_data[TICKS_W-1:0];
            default:         factor_ff <= factor_ff;
         endcase
      end
   end

   // phase sequencing and edge capture for the accepted tick
   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      rise_in  = rise_ff;
      tick_now = tick_ff;
      left_ld  = left_ff;
      left_dec = '0;
      flags_in = '0;
      unique case (phase_ff)
         PH_TRIGGER: begin
            if (left_ff == '0) begin
               tick_now = '0;
               left_ld  = (ticks_ff == '0) ? TICKS_W'(1) : ticks_ff;
            end
            left_dec      = left_ld - 1'b1;
            left_in       = left_dec;
            flags_in.trig = 1'b1;
            if (left_dec == '0) begin
               phase_in = PH_WAIT_RISE;
            end
         end
         PH_WAIT_RISE: begin
            if (req_echo_level) begin
               rise_in  = tick_ff;
               phase_in = PH_WAIT_FALL;
            end
         end
         PH_WAIT_FALL: begin
            if (!req_echo_level) begin
               if (tick_ff > rise_ff) begin
                  flags_in.fire = 1'b1;
               end else begin
                  flags_in.drop = 1'b1;
               end
               phase_in = PH_TRIGGER;
               left_in  = '0;
            end
         end
         default: begin
            phase_in = PH_TRIGGER;
            left_in  = '0;
         end
      endcase
      tick_in = tick_now + 1'b1;
   end

   // pulse width times factor
   assign width      = tick_ff - rise_ff;
   assign s1_prod_in = PROD_W'(width) * PROD_W'(factor_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TRIGGER;
         tick_ff  <= '0;
         left_ff  <= '0;
         rise_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         left_ff  <= left_in;
         rise_ff  <= rise_in;
      end
   end

   // stage 1: flags and product
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_v_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_flags_ff <= flags_in;
         s1_prod_ff  <= s1_prod_in;
      end
   end

   // stage 2: saturation check and reciprocal estimate of product / 1000
   assign prod_ext   = EXT_W'(s1_prod_ff);
   assign s2_sat_in  = prod_ext >= SAT_LIMIT;
   assign s2_p_in    = prod_ext[DIV_W-1:0];
   assign recip_prod = (DIV_W+RECIP_W)'(s2_p_in) * (DIV_W+RECIP_W)'(RECIP_1000);
   assign s2_q0_in   = recip_prod[DIV_W+RECIP_W-1:DIV_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_v_ff && s2_ready) begin
         s2_flags_ff <= s1_flags_ff;
         s2_sat_ff   <= s2_sat_in;
         s2_p_ff     <= s2_p_in;
         s2_q0_ff    <= s2_q0_in;
      end
   end

   // stage 3: quotient correction, clamp and last range update
   assign q0_times    = REM_W'(s2_q0_ff) * DIVISOR;
   assign rem         = REM_W'(s2_p_ff) - q0_times;
   assign quo         = (rem >= DIVISOR) ? s2_q0_ff + 1'b1 : s2_q0_ff;
   assign cm          = (s2_sat_ff || quo > QUO_W'(RANGE_MAX)) ? RANGE_MAX
                                                               : quo[RANGE_W-1:0];
   assign s3_range_in = s2_flags_ff.fire ? cm : last_range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff       <= 1'b0;
         last_range_ff <= '0;
      end else begin
         if (s3_ready) begin
            s3_v_ff <= s2_v_ff;
         end
         if (s2_v_ff && s3_ready) begin
            last_range_ff <= s3_range_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_v_ff && s3_ready) begin
         s3_flags_ff <= s2_flags_ff;
         s3_range_ff <= s3_range_in;
      end
   end

   // decimal digits by reciprocal multiplication, exact over the range span
   assign prod10      = (RANGE_W+DIV10_MUL_W)'(s3_range_ff) * (RANGE_W+DIV10_MUL_W)'(DIV10_MUL);
   assign q10         = prod10[DIV10_SHIFT +: Q10_W];
   assign prod100     = (RANGE_W+DIV100_MUL_W)'(s3_range_ff)
                        * (RANGE_W+DIV100_MUL_W)'(DIV100_MUL);
   assign q100        = prod100[DIV100_SHIFT +: DIGIT_W];
   assign ones_full   = s3_range_ff - RANGE_W'(q10) * RANGE_W'(DIGIT_TEN);
   assign tens_full   = q10 - Q10_W'(q100) * Q10_W'(DIGIT_TEN);
   assign hund_digit  = (q100 == DIGIT_TEN) ? '0 : q100;
   assign thou_digit  = (s3_range_ff >= THOUSAND) ? DIGIT_W'(1) : '0;
   assign rsp_ones_in = seg_pattern(ones_full[DIGIT_W-1:0]);
   assign rsp_tens_in = seg_pattern(tens_full[DIGIT_W-1:0]);
   assign rsp_hund_in = seg_pattern(hund_digit);
   assign rsp_thou_in = seg_pattern(thou_digit);

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (rsp_ready) begin
         rsp_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_v_ff && rsp_ready) begin
         rsp_trig_ff  <= s3_flags_ff.trig;
         rsp_fire_ff  <= s3_flags_ff.fire;
         rsp_drop_ff  <= s3_flags_ff.drop;
         rsp_range_ff <= s3_range_ff;
         rsp_ones_ff  <= rsp_ones_in;
         rsp_tens_ff  <= rsp_tens_in;
         rsp_hund_ff  <= rsp_hund_in;
         rsp_thou_ff  <= rsp_thou_in;
      end
   end

   assign rsp_valid         = rsp_v_ff;
   assign rsp_trigger_level = rsp_trig_ff;
   assign rsp_result_valid  = rsp_fire_ff;
   assign rsp_dropped       = rsp_drop_ff;
   assign rsp_range_cm      = rsp_range_ff;
   assign rsp_seg_ones      = rsp_ones_ff;
   assign rsp_seg_tens      = rsp_tens_ff;
   assign rsp_seg_hundreds  = rsp_hund_ff;
   assign rsp_seg_thousands = rsp_thou_ff;

endmodule

// ----- design/uer_checker.sv -----
// port-level checks of the ultrasonic echo ranger core, bound to the core module
// depends on uer_pkg and ultrasonic_echo_ranger_core

module uer_checker
   import uer_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  req_echo_level,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_trigger_level,
   input logic                  rsp_result_valid,
   input logic                  rsp_dropped,
   input logic [RANGE_W-1:0]    rsp_range_cm,
   input logic [SEG_W-1:0]      rsp_seg_ones,
   input logic [SEG_W-1:0]      rsp_seg_tens,
   input logic [SEG_W-1:0]      rsp_seg_hundreds,
   input logic [SEG_W-1:0]      rsp_seg_thousands
);

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled tick is still offered unchanged
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_echo_level))
      else $error("stalled tick changed");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_range_cm)
         && $stable(rsp_result_valid) && $stable(rsp_seg_ones))
      else $error("stalled result changed");

   // a tick is either trigger, new range, drop or idle wait
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_trigger_level, rsp_result_valid, rsp_dropped}))
      else $error("result flags overlap");

   // thousands digit of a ten-bit range is zero or one
   a_thousands_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_seg_thousands == seg_pattern(4'd0))
         || (rsp_seg_thousands == seg_pattern(4'd1)))
      else $error("thousands digit out of span");

endmodule

bind ultrasonic_echo_ranger_core uer_checker u_uer_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_echo_level    (req_echo_level),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_trigger_level (rsp_trigger_level),
   .rsp_result_valid  (rsp_result_valid),
   .rsp_dropped       (rsp_dropped),
   .rsp_range_cm      (rsp_range_cm),
   .rsp_seg_ones      (rsp_seg_ones),
   .rsp_seg_tens      (rsp_seg_tens),
   .rsp_seg_hundreds  (rsp_seg_hundreds),
   .rsp_seg_thousands (rsp_seg_thousands)
);
